[src/fsp_pkg.sv]
// ----------------------------------------------------------------------------
// Frame slot pool package
// Shared widths, counts and action codes for the frame slot pool.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

	localparam int POOL      = 8;
	localparam int IDX_W     = $clog2(POOL);
	localparam int FRAME_W   = 16;
	localparam int HANDLE_W  = 32;
	localparam int AGE_W     = 32;
	localparam int ACTION_W  = 2;
	localparam int MOD_STEPS = FRAME_W;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_STORE   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 56;

endpackage

`default_nettype wire

[src/fsp_mod.sv]
// ----------------------------------------------------------------------------
// Frame number remainder unit
// Restoring division that produces dividend modulo divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_mod
	import fsp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [FRAME_W-1:0] dividend,
	input  wire logic [FRAME_W-1:0] divisor,
	output logic                    done,
	output logic [FRAME_W-1:0]      rem
);

	logic                 run_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [FRAME_W-1:0]   rem_q;
	logic [FRAME_W-1:0]   dv_q;
	logic [FRAME_W:0]     trial;
	logic [FRAME_W:0]     diff;

	always_comb begin
		trial = {rem_q, dv_q[FRAME_W-1]};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dv_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				rem_q <= '0;
				dv_q  <= dividend;
			end else if (run_q) begin
				if (trial >= {1'b0, divisor}) begin
					rem_q <= diff[FRAME_W-1:0];
				end else begin
					rem_q <= trial[FRAME_W-1:0];
				end
				dv_q  <= {dv_q[FRAME_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

[src/frame_slot_pool_with_prefetch_top.sv]
// ----------------------------------------------------------------------------
// Frame slot pool with prefetch
// Fully associative pool of decoded-frame slots with lookup, store and a
// prefetch check on advance. One request is handled at a time.
// Lookup and store of an in-range frame scan the pool, one slot per cycle.
// Advance runs a bit-serial remainder, then up to two slot scans. A rejected
// or unused request goes straight to the finish step.
// A response that has not been taken holds the finish step until it is taken.
// Reset clears the pool valid bits, ages, counters and the frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_slot_pool_with_prefetch_top
	import fsp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [FRAME_W-1:0]   cfg_wr_data,   // frames_total
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,       // frame_number, buffer_handle
	input  wire logic [ACTION_W-1:0]  s_tuser,       // action
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata        // frame_handle, handle_valid,
	                                                 // lookup_hit, request_issue,
	                                                 // request_first
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_ASCAN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]          state_q;
	logic [FRAME_W-1:0]  frames_total_q;

	logic [FRAME_W-1:0]  slot_frame_q [POOL];
	logic [HANDLE_W-1:0] slot_handle_q [POOL];
	logic [AGE_W-1:0]    slot_age_q [POOL];
	logic [POOL-1:0]     slot_valid_q;
	logic [AGE_W-1:0]    wcnt_q;
	logic [HANDLE_W-1:0] last_handle_q;
	logic                last_valid_q;
	logic                pending_q;

	logic [ACTION_W-1:0] act_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [HANDLE_W-1:0] handle_q;
	logic                inrange_q;
	logic [IDX_W-1:0]    idx_q;
	logic                hit_q;
	logic [IDX_W-1:0]    hidx_q;
	logic [IDX_W-1:0]    vidx_q;
	logic [AGE_W-1:0]    vage_q;
	logic                ahead_q;
	logic [FRAME_W-1:0]  cand_q;
	logic                issue_q;
	logic [FRAME_W-1:0]  first_q;

	logic                m_tvalid_q;
	logic [HANDLE_W-1:0] o_handle_q;
	logic                o_hvalid_q;
	logic                o_hit_q;
	logic                o_issue_q;
	logic [FRAME_W-1:0]  o_first_q;

	logic [FRAME_W-1:0]  in_frame;
	logic [HANDLE_W-1:0] in_handle;
	logic                in_range;
	logic                accept;
	logic                mod_start;
	logic                mod_done;
	logic [FRAME_W-1:0]  mod_rem;
	logic [FRAME_W-1:0]  key;
	logic                slot_match;
	logic                age_lower;
	logic                last_idx;
	logic [FRAME_W-1:0]  inc_src;
	logic [FRAME_W:0]    inc_sum;
	logic [FRAME_W-1:0]  inc_val;
	logic                out_free;
	logic                store_wr;
	logic [AGE_W-1:0]    wcnt_next;

	assign in_frame  = s_tdata[FRAME_W-1:0];
	assign in_handle = s_tdata[FRAME_W +: HANDLE_W];
	assign in_range  = in_frame < frames_total_q;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign mod_start = accept && (s_tuser == ACT_ADVANCE) && !pending_q
		&& (frames_total_q != '0);

	fsp_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (in_frame),
		.divisor  (frames_total_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// The slot compare unit is shared by the lookup, store and advance scans.
	always_comb begin
		key        = (state_q == ST_ASCAN) ? cand_q : frame_q;
		slot_match = slot_valid_q[idx_q] && (slot_frame_q[idx_q] == key);
		age_lower  = slot_age_q[idx_q] < vage_q;
		last_idx   = (idx_q == IDX_W'(POOL - 1));
		inc_src    = (state_q == ST_MOD) ? mod_rem : cand_q;
		inc_sum    = {1'b0, inc_src} + 1'b1;
		inc_val    = (inc_sum == {1'b0, frames_total_q}) ? '0 : inc_sum[FRAME_W-1:0];
		out_free   = !m_tvalid_q || m_tready;
		store_wr   = (state_q == ST_FIN) && out_free && (act_q == ACT_STORE)
			&& inrange_q && !hit_q;
		wcnt_next  = wcnt_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (store_wr) begin
			slot_frame_q[vidx_q]  <= frame_q;
			slot_handle_q[vidx_q] <= handle_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			frames_total_q <= '0;
			slot_valid_q   <= '0;
			for (int i = 0; i < POOL; i++) begin
				slot_age_q[i] <= '0;
			end
			wcnt_q        <= '0;
			last_handle_q <= '0;
			last_valid_q  <= 1'b0;
			pending_q     <= 1'b0;
			act_q         <= '0;
			frame_q       <= '0;
			handle_q      <= '0;
			inrange_q     <= 1'b0;
			idx_q         <= '0;
			hit_q         <= 1'b0;
			hidx_q        <= '0;
			vidx_q        <= '0;
			vage_q        <= '0;
			ahead_q       <= 1'b0;
			cand_q        <= '0;
			issue_q       <= 1'b0;
			first_q       <= '0;
			m_tvalid_q    <= 1'b0;
			o_handle_q    <= '0;
			o_hvalid_q    <= 1'b0;
			o_hit_q       <= 1'b0;
			o_issue_q     <= 1'b0;
			o_first_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				frames_total_q <= cfg_wr_data;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q     <= s_tuser;
						frame_q   <= in_frame;
						handle_q  <= in_handle;
						inrange_q <= in_range;
						idx_q     <= '0;
						hit_q     <= 1'b0;
						ahead_q   <= 1'b0;
						issue_q   <= 1'b0;
						first_q   <= '0;
						case (s_tuser) inside
							ACT_LOOKUP, ACT_STORE: begin
								state_q <= in_range ? ST_SCAN : ST_FIN;
							end
							ACT_ADVANCE: begin
								state_q <= mod_start ? ST_MOD : ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (slot_match && !hit_q) begin
						hit_q  <= 1'b1;
						hidx_q <= idx_q;
					end
					if ((idx_q == '0) || age_lower) begin
						vage_q <= slot_age_q[idx_q];
						vidx_q <= idx_q;
					end
					if (last_idx) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						cand_q  <= inc_val;
						idx_q   <= '0;
						state_q <= ST_ASCAN;
					end
				end
				ST_ASCAN: begin
					if (slot_match) begin
						if (ahead_q) begin
							state_q <= ST_FIN;
						end else begin
							ahead_q <= 1'b1;
							cand_q  <= inc_val;
							idx_q   <= '0;
						end
					end else if (last_idx) begin
						issue_q <= 1'b1;
						first_q <= cand_q;
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						o_handle_q <= '0;
						o_hvalid_q <= 1'b0;
						o_hit_q    <= 1'b0;
						o_issue_q  <= 1'b0;
						o_first_q  <= '0;
						state_q    <= ST_IDLE;
						case (act_q)
							ACT_LOOKUP: begin
								if (hit_q) begin
									o_handle_q    <= slot_handle_q[hidx_q];
									o_hvalid_q    <= 1'b1;
									o_hit_q       <= 1'b1;
									last_handle_q <= slot_handle_q[hidx_q];
									last_valid_q  <= 1'b1;
								end else begin
									o_handle_q <= last_handle_q;
									o_hvalid_q <= last_valid_q;
								end
							end
							ACT_STORE: begin
								pending_q <= 1'b0;
								if (store_wr) begin
									slot_valid_q[vidx_q] <= 1'b1;
									slot_age_q[vidx_q]   <= wcnt_next;
									wcnt_q               <= wcnt_next;
								end
							end
							ACT_ADVANCE: begin
								if (issue_q) begin
									pending_q <= 1'b1;
									o_issue_q <= 1'b1;
									o_first_q <= first_q;
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, o_first_q, o_issue_q, o_hit_q, o_hvalid_q, o_handle_q};

endmodule

`default_nettype wire

[bench/frame_slot_pool_with_prefetch_top_tb.sv]
// ----------------------------------------------------------------------------
// Frame slot pool with prefetch testbench
// Drives lookup, store and advance requests into the frame slot pool over
// several frame counts, predicts every response with a scoreboard that keeps
// its own copy of the pool, and compares each response field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_slot_pool_with_prefetch_top_tb;
	import fsp_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int AHEAD_MIN     = 2;
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT   = 800000;
	localparam int PHASE_ITEMS   = 220;

	typedef struct {
		logic [HANDLE_W-1:0] handle;
		logic                hvalid;
		logic                hit;
		logic                issue;
		logic [FRAME_W-1:0]  first;
	} pool_response_t;

	class frame_pool_scoreboard;
		logic [FRAME_W-1:0]  frames_total;
		logic [FRAME_W-1:0]  slot_frame [POOL];
		logic [HANDLE_W-1:0] slot_handle [POOL];
		logic                slot_valid [POOL];
		logic [AGE_W-1:0]    slot_age [POOL];
		logic [AGE_W-1:0]    write_counter;
		logic [HANDLE_W-1:0] last_handle;
		logic                last_valid;
		logic                request_pending;
		pool_response_t      expected_responses[$];
		int                  errors;
		int                  checked;
		int                  hits;
		int                  prefetches;

		function new();
			frames_total = '0;
			for (int i = 0; i < POOL; i++) begin
				slot_frame[i] = '0;
				slot_handle[i] = '0;
				slot_valid[i] = 1'b0;
				slot_age[i] = '0;
			end
			write_counter = '0;
			last_handle = '0;
			last_valid = 1'b0;
			request_pending = 1'b0;
			errors = 0;
			checked = 0;
			hits = 0;
			prefetches = 0;
		endfunction

		function int locate_frame(int unsigned frame);
			for (int i = 0; i < POOL; i++) begin
				if (slot_valid[i] && slot_frame[i] == frame)
					return i;
			end
			return -1;
		endfunction

		function void note_request(logic [ACTION_W-1:0] action, logic [FRAME_W-1:0] frame,
				logic [HANDLE_W-1:0] handle);
			pool_response_t rsp;
			int             s;
			int             victim;
			int unsigned    ahead;
			rsp = '{default: '0};
			case (action)
				ACT_LOOKUP: begin
					s = (frame < frames_total) ? locate_frame(frame) : -1;
					if (s >= 0) begin
						last_handle = slot_handle[s];
						last_valid = 1'b1;
						rsp.handle = slot_handle[s];
						rsp.hvalid = 1'b1;
						rsp.hit = 1'b1;
					end else begin
						rsp.handle = last_handle;
						rsp.hvalid = last_valid;
					end
				end
				ACT_STORE: begin
					request_pending = 1'b0;
					if (frame < frames_total && locate_frame(frame) < 0) begin
						victim = 0;
						for (int i = 1; i < POOL; i++) begin
							if (slot_age[i] < slot_age[victim])
								victim = i;
						end
						write_counter = write_counter + 1;
						slot_frame[victim] = frame;
						slot_handle[victim] = handle;
						slot_valid[victim] = 1'b1;
						slot_age[victim] = write_counter;
					end
				end
				ACT_ADVANCE: begin
					if (!request_pending && frames_total != 0) begin
						ahead = 0;
						for (int unsigned off = 1; off <= POOL; off++) begin
							if (locate_frame((int'(frame) + off) % frames_total) >= 0)
								ahead++;
							else
								break;
						end
						if (ahead < AHEAD_MIN) begin
							request_pending = 1'b1;
							rsp.issue = 1'b1;
							rsp.first = FRAME_W'((int'(frame) + ahead + 1) % frames_total);
						end
					end
				end
				default: ;
			endcase
			expected_responses.push_back(rsp);
		endfunction

		function void report_field(string name, longint unsigned exp_v,
				longint unsigned act_v);
			if (exp_v != act_v) begin
				errors++;
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_response(logic [M_TDATA_W-1:0] data);
			pool_response_t exp_r;
			if (expected_responses.size() == 0) begin
				errors++;
				$display("%0t: unexpected response: expected none, actual %h", $time, data);
				return;
			end
			exp_r = expected_responses.pop_front();
			checked++;
			if (exp_r.hit)
				hits++;
			if (exp_r.issue)
				prefetches++;
			report_field("frame_handle", exp_r.handle, data[31:0]);
			report_field("handle_valid", exp_r.hvalid, data[32]);
			report_field("lookup_hit", exp_r.hit, data[33]);
			report_field("request_issue", exp_r.issue, data[34]);
			report_field("request_first", exp_r.first, data[50:35]);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [FRAME_W-1:0]   cfg_wr_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [ACTION_W-1:0]  s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	frame_pool_scoreboard sb = new();
	int send_idle;
	int recv_idle;
	int items_sent;
	int settings_used;
	int cycles;

	frame_slot_pool_with_prefetch_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_response(m_tdata);
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_item(logic [ACTION_W-1:0] action, logic [FRAME_W-1:0] frame,
			logic [HANDLE_W-1:0] handle);
		if (items_sent < 600) begin
			send_idle = 18;
			recv_idle = 70;
		end else if (items_sent < 1200) begin
			send_idle = 70;
			recv_idle = 18;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= action;
		s_tdata <= {handle, frame};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(action, frame, handle);
		items_sent++;
	endtask

	task automatic set_frame_count(logic [FRAME_W-1:0] count);
		s_tvalid <= 1'b0;
		while (sb.expected_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= count;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.frames_total = count;
		settings_used++;
	endtask

	task automatic run_directed();
		// With no frames configured nothing hits, stores are skipped and advance is inert.
		send_item(ACT_LOOKUP, 16'd0, 32'h0);
		send_item(ACT_STORE, 16'd0, 32'h1234_5678);
		send_item(ACT_ADVANCE, 16'd0, 32'h0);
		send_item(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
		set_frame_count(16'hFFFF);
		send_item(ACT_STORE, 16'hFFFE, 32'hFFFF_FFFF);
		send_item(ACT_STORE, 16'd0, 32'h0);
		send_item(ACT_STORE, 16'hFFFF, 32'hDEAD_BEEF);
		send_item(ACT_LOOKUP, 16'hFFFF, 32'h0);
		send_item(ACT_LOOKUP, 16'hFFFE, 32'h0);
		send_item(ACT_LOOKUP, 16'd5, 32'h0);
		send_item(ACT_ADVANCE, 16'hFFFF, 32'h0);
		send_item(ACT_ADVANCE, 16'hFFFF, 32'h0);
		send_item(ACT_STORE, 16'hFFFE, 32'hAAAA_5555);
		send_item(ACT_ADVANCE, 16'hFFFD, 32'h0);
		send_item(ACT_LOOKUP, 16'd0, 32'h0);
		set_frame_count(16'd4);
		for (int i = 0; i < 5; i++)
			send_item(ACT_STORE, 16'(i), $urandom);
		send_item(ACT_ADVANCE, 16'd10, 32'h0);
		send_item(ACT_LOOKUP, 16'd3, 32'h0);
		send_item(ACT_UNUSED, 16'd1, $urandom);
		send_item(ACT_ADVANCE, 16'd2, 32'h0);
	endtask

	task automatic run_random_phase(int count);
		int unsigned         span;
		int unsigned         cursor;
		int unsigned         r;
		logic [ACTION_W-1:0] action;
		logic [FRAME_W-1:0]  frame;
		span = (sb.frames_total == 0) ? 16 : sb.frames_total;
		cursor = $urandom_range(65535) % span;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 5) begin
				send_item(ACT_UNUSED, 16'($urandom), $urandom);
			end else if (r < 15) begin
				send_item(ACTION_W'($urandom_range(2)), 16'($urandom), $urandom);
			end else begin
				r = $urandom_range(99);
				if (r < 38)
					action = ACT_STORE;
				else if (r < 75)
					action = ACT_LOOKUP;
				else
					action = ACT_ADVANCE;
				if (action == ACT_ADVANCE) begin
					frame = ($urandom_range(3) == 0) ? 16'(cursor + span) : 16'(cursor);
					if ($urandom_range(1) == 1)
						cursor = (cursor + 1) % span;
				end else if ($urandom_range(9) == 0) begin
					frame = 16'(sb.frames_total + $urandom_range(3));
				end else begin
					frame = 16'((cursor + $urandom_range(9)) % span);
				end
				send_item(action, frame, $urandom);
			end
		end
	endtask

	initial begin
		logic [FRAME_W-1:0] counts [8];
		arst_n = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_LOOKUP;
		items_sent = 0;
		settings_used = 0;
		send_idle = 18;
		recv_idle = 70;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		run_directed();
		counts = '{16'd12, 16'd1, 16'hFFFF, 16'd9, 16'd0, 16'd2,
			16'($urandom_range(3, 64)), 16'd40};
		foreach (counts[i]) begin
			set_frame_count(counts[i]);
			run_random_phase(PHASE_ITEMS);
		end
		s_tvalid <= 1'b0;
		while (sb.expected_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.expected_responses.size() != 0)
			sb.errors++;
		$display("Sent %0d requests under %0d frame counts; %0d responses compared.",
			items_sent, settings_used, sb.checked);
		$display("Responses included %0d lookup hits and %0d prefetch requests.",
			sb.hits, sb.prefetches);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

[frame_slot_pool_with_prefetch_top.f]
src/fsp_pkg.sv
src/fsp_mod.sv
src/frame_slot_pool_with_prefetch_top.sv
bench/frame_slot_pool_with_prefetch_top_tb.sv
